>>> design/gsdhp_pkg.sv
// types and constants shared by the dual-history gshare predictor
// no dependencies; imported by the top level, its checker and the testbench
`default_nettype none

package gsdhp_pkg;

    // fixed port widths
    localparam int PC_W      = 64;
    localparam int SNAP_W    = 12;
    localparam int SHIFT_W   = 6;
    localparam int THREAD_W  = 2;
    localparam int CFG_ADDR_W = 1;

    // operation codes
    typedef enum logic [2:0] {
        OP_LOOKUP         = 3'd0,
        OP_HIST_UPDATE    = 3'd1,
        OP_SQUASH_RESTORE = 3'd2,
        OP_COMMIT_UPDATE  = 3'd3,
        OP_SQUASH_UPDATE  = 3'd4
    } t_op;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_SHIFT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SELECT_SHIFT = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd2;

endpackage

`default_nettype wire

>>> design/gshare_dual_history_predictor.sv
// gshare predictor with an even and an odd global history per thread
// depends on gsdhp_pkg; checked by gsdhp_checker (bound from its own file)
//
// usage:
//   command channel: drive i_op and its operands with i_start high; the word is
//   taken at a rising edge where i_start is high and o_busy is low.
//   result channel: exactly one result per command, shown for one cycle with
//   o_valid high; the receiver cannot stall it, so it must sample o_valid.
//   config port: i_cfg_we / i_cfg_addr / i_cfg_wdata write index_shift (0) and
//   select_shift (1) at any edge out of reset; write them only while no command is in flight.
// latency: the result appears in the cycle after the command is taken.
// throughput: one command per cycle while o_busy is low. the counter table is
//   a single synchronous memory read when a command is taken and written back
//   next cycle; a commit writing the entry the next command reads is forwarded.
// history registers are updated at the edge that takes the command, so the
//   next command already sees the new history.
// reset: synchronous, active low. histories and shifts go to their reset
//   values; then a clearing pass zeroes the counter table, one entry per
//   cycle, with o_busy high. config writes still work.
`default_nettype none

module gshare_dual_history_predictor
    import gsdhp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int COUNTER_BITS  = 2,
    parameter int THREADS       = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [SHIFT_W-1:0]    i_cfg_wdata,
    input  wire logic [2:0]            i_op,
    input  wire logic [THREAD_W-1:0]   i_thread,
    input  wire logic [PC_W-1:0]       i_pc,
    input  wire logic                  i_outcome_taken,
    input  wire logic                  i_is_uncond,
    input  wire logic [SNAP_W-1:0]     i_saved_history,
    input  wire logic                  i_saved_odd,
    output logic                       o_valid,
    output logic                       o_predict_taken,
    output logic [SNAP_W-1:0]          o_snapshot_history,
    output logic                       o_snapshot_odd
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int HIST_W = IDX_W;
    localparam int CTR_W = COUNTER_BITS;
    localparam int THR_W = (THREADS > 1) ? $clog2(THREADS) : 1;

    // configuration
    logic [SHIFT_W-1:0] r_index_shift;
    logic [SHIFT_W-1:0] r_select_shift;

    // history registers
    logic [HIST_W-1:0] r_hist_even [THREADS];
    logic [HIST_W-1:0] r_hist_odd  [THREADS];

    // counter table
    logic [CTR_W-1:0] mem_ctr [TABLE_ENTRIES];
    logic [CTR_W-1:0] r_rd_data;

    // clearing pass
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_addr;

    // result stage
    logic              r_s1_valid;
    logic              r_s1_ok;
    t_op               r_s1_op;
    logic [IDX_W-1:0]  r_s1_addr;
    logic              r_s1_taken;
    logic              r_s1_uncond;
    logic [SNAP_W-1:0] r_s1_snap;
    logic              r_s1_odd;

    // last counter write, for read-during-write on the same entry
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    logic [CTR_W-1:0] r_fwd_data;

    logic              accept;
    logic              op_known;
    logic              n_ok;
    logic [THR_W-1:0]  thr;
    logic [PC_W-1:0]   sel_sh;
    logic [PC_W-1:0]   idx_sh;
    logic              sel_odd;
    logic [HIST_W-1:0] hist_prev;
    logic [HIST_W-1:0] saved_h;
    logic [HIST_W-1:0] n_hist;
    logic              hist_we;
    logic [IDX_W-1:0]  rd_addr;
    logic [CTR_W-1:0]  ctr_cur;
    logic [CTR_W-1:0]  n_ctr;
    logic              commit_we;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CTR_W-1:0]  mem_wdata;

    assign accept = i_start && !r_clearing;
    assign o_busy = r_clearing;

    always_comb begin
        case (i_op)
            OP_LOOKUP, OP_HIST_UPDATE, OP_SQUASH_RESTORE,
            OP_COMMIT_UPDATE, OP_SQUASH_UPDATE: op_known = 1'b1;
            default:                            op_known = 1'b0;
        endcase
    end

    assign n_ok      = op_known && (32'(i_thread) < THREADS);
    assign thr       = THR_W'(i_thread);
    assign sel_sh    = i_pc >> r_select_shift;
    assign idx_sh    = i_pc >> r_index_shift;
    assign saved_h   = HIST_W'(i_saved_history);
    assign sel_odd   = (i_op inside {OP_SQUASH_RESTORE, OP_SQUASH_UPDATE})
                       ? i_saved_odd : sel_sh[0];
    assign hist_prev = sel_odd ? r_hist_odd[thr] : r_hist_even[thr];
    assign rd_addr   = idx_sh[IDX_W-1:0] ^ ((i_op == OP_COMMIT_UPDATE) ? saved_h : hist_prev);

    always_comb begin
        n_hist  = hist_prev;
        hist_we = 1'b0;
        case (i_op)
            OP_HIST_UPDATE: begin
                n_hist  = HIST_W'({hist_prev, i_outcome_taken});
                hist_we = 1'b1;
            end
            OP_SQUASH_RESTORE: begin
                n_hist  = saved_h;
                hist_we = 1'b1;
            end
            OP_SQUASH_UPDATE: begin
                n_hist  = HIST_W'({saved_h, i_outcome_taken});
                hist_we = 1'b1;
            end
            default: begin
                n_hist  = hist_prev;
                hist_we = 1'b0;
            end
        endcase
    end

    // counter seen by the item in the result stage
    assign ctr_cur = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_data : r_rd_data;

    always_comb begin
        n_ctr = ctr_cur;
        if (r_s1_taken) begin
            if (ctr_cur != {CTR_W{1'b1}}) begin
                n_ctr = ctr_cur + CTR_W'(1);
            end
        end else if (ctr_cur != '0) begin
            n_ctr = ctr_cur - CTR_W'(1);
        end
    end

    assign commit_we = r_s1_valid && r_s1_ok && r_s1_op == OP_COMMIT_UPDATE;
    assign mem_we    = r_clearing || commit_we;
    assign mem_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign mem_wdata = r_clearing ? '0 : n_ctr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_ctr[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= mem_ctr[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_shift  <= SHIFT_RESET;
            r_select_shift <= SHIFT_RESET;
            for (int t = 0; t < THREADS; t++) begin
                r_hist_even[t] <= '0;
                r_hist_odd[t]  <= '0;
            end
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_INDEX_SHIFT:  r_index_shift  <= i_cfg_wdata;
                    CFG_SELECT_SHIFT: r_select_shift <= i_cfg_wdata;
                    default:          r_index_shift  <= r_index_shift;
                endcase
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == {IDX_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept && n_ok && hist_we) begin
                if (sel_odd) begin
                    r_hist_odd[thr] <= n_hist;
                end else begin
                    r_hist_even[thr] <= n_hist;
                end
            end
            r_s1_valid  <= accept;
            r_fwd_valid <= commit_we;
        end
    end

    // payload of the result stage and the forward path
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok     <= n_ok;
            r_s1_op     <= t_op'(i_op);
            r_s1_addr   <= rd_addr;
            r_s1_taken  <= i_outcome_taken;
            r_s1_uncond <= i_is_uncond;
            r_s1_snap   <= n_ok ? SNAP_W'(hist_prev) : '0;
            r_s1_odd    <= n_ok && sel_odd;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= n_ctr;
    end

    assign o_valid            = r_s1_valid;
    assign o_predict_taken    = r_s1_ok &&
                                ((r_s1_op == OP_LOOKUP && ctr_cur[CTR_W-1]) ||
                                 (r_s1_op == OP_HIST_UPDATE && r_s1_uncond));
    assign o_snapshot_history = r_s1_snap;
    assign o_snapshot_odd     = r_s1_odd;

endmodule

`default_nettype wire

>>> design/gsdhp_checker.sv
// port-level checks for the dual-history gshare predictor
// depends on gsdhp_pkg; bound to gshare_dual_history_predictor below
`default_nettype none

module gsdhp_checker
    import gsdhp_pkg::*;
#(
    parameter int THREADS = 4
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_start,
    input wire logic                o_busy,
    input wire logic [2:0]          i_op,
    input wire logic [THREAD_W-1:0] i_thread,
    input wire logic                i_is_uncond,
    input wire logic                i_saved_odd,
    input wire logic                o_valid,
    input wire logic                o_predict_taken,
    input wire logic                o_snapshot_odd
);

    // a taken command gives a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_valid)
        else $error("command taken without a result");

    // no result without a command
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy))
        else $error("result without a command");

    // the table is cleared after reset before any command
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_busy)
        else $error("not busy right after reset");

    // only a lookup or an unconditional history update predicts taken
    a_taken_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_predict_taken |->
            $past(i_op == OP_LOOKUP || (i_op == OP_HIST_UPDATE && i_is_uncond)))
        else $error("taken prediction from wrong op");

    // squash ops select the register named by the snapshot
    a_squash_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past((i_op == OP_SQUASH_RESTORE || i_op == OP_SQUASH_UPDATE)
                         && 32'(i_thread) < THREADS)
            |-> o_snapshot_odd == $past(i_saved_odd))
        else $error("squash selected the wrong history register");

endmodule

bind gshare_dual_history_predictor gsdhp_checker #(.THREADS(THREADS)) u_gsdhp_checker (.*);

`default_nettype wire

>>> tb/gshare_dual_history_predictor_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for gshare_dual_history_predictor
// depends on gsdhp_pkg and the design; a directed table, then random words per shift setting

module gshare_dual_history_predictor_tb;
    import gsdhp_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int COUNTER_BITS  = 2;
    localparam int THREADS       = 4;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int N_RANDOM      = 800;
    localparam int N_PHASES      = 8;
    localparam int SNAP_POOL     = 32;
    localparam int PC_POOL       = 16;
    localparam logic [COUNTER_BITS-1:0] CTR_MAX = '1;

    typedef struct {
        logic [2:0]          op;
        logic [THREAD_W-1:0] thread;
        logic [PC_W-1:0]     pc;
        logic                taken;
        logic                uncond;
        logic [SNAP_W-1:0]   saved;
        logic                saved_odd;
    } t_word;

    typedef struct {
        logic              taken;
        logic [SNAP_W-1:0] hist;
        logic              odd;
    } t_prediction;

    typedef struct {
        t_word       w;
        bit          typed;
        t_prediction res;
    } t_row;

    typedef struct {
        logic [PC_W-1:0]     pc;
        logic [SNAP_W-1:0]   hist;
        logic                odd;
        logic [THREAD_W-1:0] thread;
    } t_snap;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [SHIFT_W-1:0]    i_cfg_wdata;
    logic [2:0]            i_op;
    logic [THREAD_W-1:0]   i_thread;
    logic [PC_W-1:0]       i_pc;
    logic                  i_outcome_taken;
    logic                  i_is_uncond;
    logic [SNAP_W-1:0]     i_saved_history;
    logic                  i_saved_odd;
    logic                  o_valid;
    logic                  o_predict_taken;
    logic [SNAP_W-1:0]     o_snapshot_history;
    logic                  o_snapshot_odd;

    // predictor state
    logic [COUNTER_BITS-1:0] sat_ctr [TABLE_ENTRIES];
    logic [SNAP_W-1:0]       ghist_even [THREADS];
    logic [SNAP_W-1:0]       ghist_odd [THREADS];
    logic [SHIFT_W-1:0]      cfg_index_shift;
    logic [SHIFT_W-1:0]      cfg_select_shift;

    t_prediction     expected_results [$];
    t_row            directed_rows [$];
    t_snap           recent_snaps [$];
    logic [PC_W-1:0] pc_pool [$];
    int              error_count;
    int              cycle_count = 0;

    gshare_dual_history_predictor #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .COUNTER_BITS (COUNTER_BITS),
        .THREADS      (THREADS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_op              (i_op),
        .i_thread          (i_thread),
        .i_pc              (i_pc),
        .i_outcome_taken   (i_outcome_taken),
        .i_is_uncond       (i_is_uncond),
        .i_saved_history   (i_saved_history),
        .i_saved_odd       (i_saved_odd),
        .o_valid           (o_valid),
        .o_predict_taken   (o_predict_taken),
        .o_snapshot_history(o_snapshot_history),
        .o_snapshot_odd    (o_snapshot_odd)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    // works out the result of one word and advances the predictor state
    task automatic predict_word(input t_word w, output t_prediction r);
        logic [PC_W-1:0]         shifted;
        logic                    odd;
        logic [SNAP_W-1:0]       hist_prev;
        logic [SNAP_W-1:0]       next_hist;
        logic [SNAP_W-1:0]       idx;
        logic [COUNTER_BITS-1:0] c;
        bit                      writes_hist;
        r.taken = 1'b0;
        r.hist  = '0;
        r.odd   = 1'b0;
        if (w.op > OP_SQUASH_UPDATE || int'(w.thread) >= THREADS) begin
            return;
        end
        shifted = w.pc >> cfg_select_shift;
        if (w.op == OP_SQUASH_RESTORE || w.op == OP_SQUASH_UPDATE) begin
            odd = w.saved_odd;
        end else begin
            odd = shifted[0];
        end
        hist_prev   = odd ? ghist_odd[w.thread] : ghist_even[w.thread];
        shifted     = w.pc >> cfg_index_shift;
        next_hist   = hist_prev;
        writes_hist = 1'b1;
        case (w.op)
            OP_LOOKUP: begin
                idx         = shifted[SNAP_W-1:0] ^ hist_prev;
                r.taken     = sat_ctr[idx][COUNTER_BITS-1];
                writes_hist = 1'b0;
            end
            OP_HIST_UPDATE: begin
                next_hist = {hist_prev[SNAP_W-2:0], w.taken};
                r.taken   = w.uncond;
            end
            OP_SQUASH_RESTORE: begin
                next_hist = w.saved;
            end
            OP_COMMIT_UPDATE: begin
                idx = shifted[SNAP_W-1:0] ^ w.saved;
                c   = sat_ctr[idx];
                if (w.taken && c != CTR_MAX) begin
                    c = c + 1'b1;
                end else if (!w.taken && c != '0) begin
                    c = c - 1'b1;
                end
                sat_ctr[idx] = c;
                writes_hist  = 1'b0;
            end
            default: begin
                next_hist = {w.saved[SNAP_W-2:0], w.taken};
            end
        endcase
        if (writes_hist) begin
            if (odd) begin
                ghist_odd[w.thread] = next_hist;
            end else begin
                ghist_even[w.thread] = next_hist;
            end
        end
        r.hist = hist_prev;
        r.odd  = odd;
    endtask

    task automatic add_row(input logic [2:0] op, input logic [THREAD_W-1:0] thr,
                           input logic [PC_W-1:0] pc, input logic tk, input logic un,
                           input logic [SNAP_W-1:0] sh, input logic so, input bit typed,
                           input logic ep, input logic [SNAP_W-1:0] eh, input logic eo);
        t_row r;
        r.w.op        = op;
        r.w.thread    = thr;
        r.w.pc        = pc;
        r.w.taken     = tk;
        r.w.uncond    = un;
        r.w.saved     = sh;
        r.w.saved_odd = so;
        r.typed       = typed;
        r.res.taken   = ep;
        r.res.hist    = eh;
        r.res.odd     = eo;
        directed_rows.push_back(r);
    endtask

    task automatic issue_word(input t_word w, input bit typed, input t_prediction typed_res);
        t_prediction p;
        t_snap       s;
        i_op            <= w.op;
        i_thread        <= w.thread;
        i_pc            <= w.pc;
        i_outcome_taken <= w.taken;
        i_is_uncond     <= w.uncond;
        i_saved_history <= w.saved;
        i_saved_odd     <= w.saved_odd;
        i_start         <= 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_word(w, p);
        if (typed) begin
            expected_results.push_back(typed_res);
        end else begin
            expected_results.push_back(p);
        end
        // keep snapshots around so later restores and commits look like real traffic
        if (w.op == OP_LOOKUP || w.op == OP_HIST_UPDATE) begin
            s.pc     = w.pc;
            s.hist   = p.hist;
            s.odd    = p.odd;
            s.thread = w.thread;
            recent_snaps.push_back(s);
            if (recent_snaps.size() > SNAP_POOL) begin
                void'(recent_snaps.pop_front());
            end
        end
    endtask

    function automatic t_word random_word();
        t_word w;
        t_snap s;
        int    sel;
        w.thread    = THREAD_W'($urandom_range(THREADS - 1));
        w.taken     = 1'($urandom_range(1));
        w.uncond    = 1'($urandom_range(1));
        w.saved     = SNAP_W'($urandom);
        w.saved_odd = 1'($urandom_range(1));
        if ($urandom_range(99) < 60) begin
            w.pc = pc_pool[$urandom_range(PC_POOL - 1)];
        end else begin
            w.pc = {$urandom, $urandom};
        end
        if (recent_snaps.size() != 0 && $urandom_range(99) < 85) begin
            s = recent_snaps[$urandom_range(recent_snaps.size() - 1)];
        end else begin
            s.pc     = {$urandom, $urandom};
            s.hist   = SNAP_W'($urandom);
            s.odd    = 1'($urandom_range(1));
            s.thread = THREAD_W'($urandom_range(THREADS - 1));
        end
        sel = $urandom_range(99);
        if (sel < 30) begin
            w.op = OP_LOOKUP;
        end else if (sel < 55) begin
            w.op = OP_HIST_UPDATE;
        end else if (sel < 65) begin
            w.op        = OP_SQUASH_RESTORE;
            w.thread    = s.thread;
            w.saved     = s.hist;
            w.saved_odd = s.odd;
        end else if (sel < 85) begin
            w.op     = OP_COMMIT_UPDATE;
            w.thread = s.thread;
            w.pc     = s.pc;
            w.saved  = s.hist;
        end else if (sel < 95) begin
            w.op        = OP_SQUASH_UPDATE;
            w.thread    = s.thread;
            w.saved     = s.hist;
            w.saved_odd = s.odd;
        end else begin
            w.op = 3'($urandom_range(7, 5));
        end
        return w;
    endfunction

    task automatic idle_gap(input bit quiet);
        if (!quiet) begin
            while ($urandom_range(99) < 13) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        i_start <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_shifts(input logic [SHIFT_W-1:0] idx_sh,
                                input logic [SHIFT_W-1:0] sel_sh);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_INDEX_SHIFT;
        i_cfg_wdata <= idx_sh;
        @(posedge i_clk);
        cfg_index_shift = idx_sh;
        i_cfg_addr  <= CFG_SELECT_SHIFT;
        i_cfg_wdata <= sel_sh;
        @(posedge i_clk);
        cfg_select_shift = sel_sh;
        i_cfg_we <= 1'b0;
    endtask

    // results are sampled at the edge that ends their cycle
    always @(posedge i_clk) begin
        t_prediction e;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                e = expected_results.pop_front();
                if (o_predict_taken !== e.taken) begin
                    report_mismatch($sformatf("predict_taken got %b want %b",
                                              o_predict_taken, e.taken));
                end
                if (o_snapshot_history !== e.hist) begin
                    report_mismatch($sformatf("snapshot_history got %h want %h",
                                              o_snapshot_history, e.hist));
                end
                if (o_snapshot_odd !== e.odd) begin
                    report_mismatch($sformatf("snapshot_odd got %b want %b",
                                              o_snapshot_odd, e.odd));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [SHIFT_W-1:0] idx_sh;
        logic [SHIFT_W-1:0] sel_sh;
        logic [PC_W-1:0]    ones;
        t_word              w;
        t_prediction        none;
        int                 n;
        error_count     = 0;
        ones            = '1;
        none.taken      = 1'b0;
        none.hist       = '0;
        none.odd        = 1'b0;
        i_rst_n         <= 1'b0;
        i_start         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_addr      <= CFG_INDEX_SHIFT;
        i_cfg_wdata     <= '0;
        i_op            <= OP_LOOKUP;
        i_thread        <= '0;
        i_pc            <= '0;
        i_outcome_taken <= 1'b0;
        i_is_uncond     <= 1'b0;
        i_saved_history <= '0;
        i_saved_odd     <= 1'b0;
        foreach (sat_ctr[k]) sat_ctr[k] = '0;
        foreach (ghist_even[k]) ghist_even[k] = '0;
        foreach (ghist_odd[k]) ghist_odd[k] = '0;
        cfg_index_shift  = SHIFT_RESET;
        cfg_select_shift = SHIFT_RESET;

        // fresh state, extremes of pc, uncond update, unknown ops
        add_row(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 1, 1'b0, '0, 1'b0);
        add_row(OP_LOOKUP, 2'd3, ones, 1'b1, 1'b1, '1, 1'b1, 1, 1'b0, '0, 1'b1);
        add_row(OP_HIST_UPDATE, 2'd0, '0, 1'b1, 1'b1, '0, 1'b0, 1, 1'b1, '0, 1'b0);
        add_row(OP_HIST_UPDATE, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        add_row(3'd5, 2'd1, ones, 1'b1, 1'b1, '1, 1'b1, 1, 1'b0, '0, 1'b0);
        add_row(3'd6, 2'd2, ones, 1'b1, 1'b1, '1, 1'b1, 1, 1'b0, '0, 1'b0);
        add_row(3'd7, 2'd3, ones, 1'b1, 1'b1, '1, 1'b1, 1, 1'b0, '0, 1'b0);
        // train one counter up past saturation, then read it
        add_row(OP_SQUASH_RESTORE, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        repeat (4) add_row(OP_COMMIT_UPDATE, 2'd0, '0, 1'b1, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        add_row(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        add_row(OP_SQUASH_RESTORE, 2'd2, '0, 1'b0, 1'b0, '1, 1'b1, 1, 1'b0, '0, 1'b1);
        add_row(OP_SQUASH_UPDATE, 2'd2, '0, 1'b1, 1'b0, '1, 1'b1, 0, 1'b0, '0, 1'b0);
        add_row(OP_SQUASH_UPDATE, 2'd2, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        // same entry trained down past zero
        repeat (5) add_row(OP_COMMIT_UPDATE, 2'd1, ones, 1'b0, 1'b0, '1, 1'b0, 0,
                           1'b0, '0, 1'b0);
        add_row(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);
        // back-to-back commits then a lookup of the same entry
        repeat (2) add_row(OP_COMMIT_UPDATE, 2'd0, '0, 1'b1, 1'b0, '0, 1'b0, 0,
                           1'b0, '0, 1'b0);
        add_row(OP_LOOKUP, 2'd0, '0, 1'b0, 1'b0, '0, 1'b0, 0, 1'b0, '0, 1'b0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            issue_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].res);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin idx_sh = '0; sel_sh = '0; end
                1: begin idx_sh = '1; sel_sh = '1; end
                2: begin idx_sh = '0; sel_sh = '1; end
                3: begin idx_sh = '1; sel_sh = '0; end
                4: begin idx_sh = SHIFT_RESET; sel_sh = SHIFT_RESET; end
                default: begin
                    idx_sh = SHIFT_W'($urandom_range(63));
                    sel_sh = SHIFT_W'($urandom_range(63));
                end
            endcase
            write_shifts(idx_sh, sel_sh);
            pc_pool.delete();
            repeat (PC_POOL) pc_pool.push_back({$urandom, $urandom});
            n = 0;
            while (n < N_RANDOM / N_PHASES) begin
                w = random_word();
                issue_word(w, 0, none);
                if (w.op <= OP_SQUASH_UPDATE) begin
                    n++;
                end
                // one phase runs with no gaps at all
                idle_gap(phase == 2);
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
